[rtl/fixed_point_pid_controller_top_assert.svh]
// Assertion macros shared by the PID controller RTL.
// Each macro expects clk_i and rst_ni to be visible at the point of use.
`ifndef FIXED_POINT_PID_CONTROLLER_TOP_ASSERT_SVH
`define FIXED_POINT_PID_CONTROLLER_TOP_ASSERT_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FPID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define FPID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/fpid_pkg.sv]
// ----------------------------------------------------------------------------
// fpid_pkg
// Types, constants, microcode table and arithmetic helpers of the PID block.
// ----------------------------------------------------------------------------
package fpid_pkg;

  // Fixed-point scaling of the gains and of every reported value.
  localparam int unsigned FRAC_BITS = 10;

  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  // Field widths.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned PER_W  = 16;
  localparam int unsigned ERR_W  = 33;
  localparam int unsigned DIFF_W = 34;
  localparam int unsigned MAG_W  = 33;
  localparam int unsigned MUL_W  = 34;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_KP    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PER   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAX  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMIN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OMAX  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_OMIN  = 3'd7;

  // Divider runs one quotient bit per iteration.
  localparam int unsigned DIV_STEPS = MAG_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS + 1);

  // Microcode step addresses.
  localparam int unsigned STEP_W = 4;
  localparam logic [STEP_W-1:0] STEP_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] STEP_MUL_P = 4'd1;
  localparam logic [STEP_W-1:0] STEP_SAT_P = 4'd2;
  localparam logic [STEP_W-1:0] STEP_SAT_K = 4'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_I = 4'd4;
  localparam logic [STEP_W-1:0] STEP_SAT_I = 4'd5;
  localparam logic [STEP_W-1:0] STEP_INTEG = 4'd6;
  localparam logic [STEP_W-1:0] STEP_DIV   = 4'd7;
  localparam logic [STEP_W-1:0] STEP_QUO   = 4'd8;
  localparam logic [STEP_W-1:0] STEP_MUL_D = 4'd9;
  localparam logic [STEP_W-1:0] STEP_SAT_D = 4'd10;
  localparam logic [STEP_W-1:0] STEP_TOTAL = 4'd11;

  // Operand pairing of the shared multiplier.
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_KP_ERR,
    MUL_KI_ERR,
    MUL_TMP_PER,
    MUL_KD_QUO
  } mul_op_e;

  // Destination of the saturated product.
  typedef enum logic [1:0] {
    SAT_NONE,
    SAT_P,
    SAT_TMP,
    SAT_D
  } sat_dst_e;

  // Adder and clamp operations.
  typedef enum logic [1:0] {
    ALU_NONE,
    ALU_INTEG,
    ALU_QUO,
    ALU_TOTAL
  } alu_op_e;

  // Condition under which a step jumps to its target instead of moving on.
  typedef enum logic [1:0] {
    COND_NONE,
    COND_NO_INPUT,
    COND_DIV_BUSY,
    COND_OUT_BUSY
  } cond_e;

  // Divider control.
  typedef struct packed {
    logic start;
    logic step;
  } div_ctrl_t;

  // One microcode word.
  typedef struct packed {
    mul_op_e           mul;
    sat_dst_e          sat;
    alu_op_e           alu;
    div_ctrl_t         div;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ucode_t;

  // Control program.
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul: MUL_NONE, sat: SAT_NONE, alu: ALU_NONE, div: '0,
          cond: COND_NONE, target: STEP_IDLE, last: 1'b0};
    unique case (step)
      STEP_IDLE: begin
        w.cond   = COND_NO_INPUT;
        w.target = STEP_IDLE;
      end
      STEP_MUL_P: w.mul = MUL_KP_ERR;
      STEP_SAT_P: begin
        w.sat = SAT_P;
        w.mul = MUL_KI_ERR;
      end
      STEP_SAT_K: w.sat = SAT_TMP;
      STEP_MUL_I: w.mul = MUL_TMP_PER;
      STEP_SAT_I: w.sat = SAT_TMP;
      STEP_INTEG: begin
        w.alu       = ALU_INTEG;
        w.div.start = 1'b1;
      end
      STEP_DIV: begin
        w.div.step = 1'b1;
        w.cond     = COND_DIV_BUSY;
        w.target   = STEP_DIV;
      end
      STEP_QUO:   w.alu = ALU_QUO;
      STEP_MUL_D: w.mul = MUL_KD_QUO;
      STEP_SAT_D: w.sat = SAT_D;
      STEP_TOTAL: begin
        w.alu    = ALU_TOTAL;
        w.cond   = COND_OUT_BUSY;
        w.target = STEP_TOTAL;
        w.last   = 1'b1;
      end
      default: w.last = 1'b1;
    endcase
    return w;
  endfunction

  // Saturate a full-width product to the signed 32-bit range.
  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
    if (v[PROD_W-1:DATA_W-1] == {(PROD_W-DATA_W+1){v[PROD_W-1]}}) begin
      return v[DATA_W-1:0];
    end
    return v[PROD_W-1] ? WORD_MIN : WORD_MAX;
  endfunction

  // Upper limit first, then lower limit, so inverted limits give one of the two.
  function automatic logic signed [DATA_W-1:0] clamp32(input logic signed [DIFF_W-1:0] v,
                                                       input logic signed [DATA_W-1:0] hi,
                                                       input logic signed [DATA_W-1:0] lo);
    logic signed [DIFF_W-1:0] hi_x;
    logic signed [DIFF_W-1:0] lo_x;
    hi_x = {{(DIFF_W-DATA_W){hi[DATA_W-1]}}, hi};
    lo_x = {{(DIFF_W-DATA_W){lo[DATA_W-1]}}, lo};
    if (v > hi_x) begin
      return hi;
    end
    if (v < lo_x) begin
      return lo;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

[rtl/fpid_div.sv]
// ----------------------------------------------------------------------------
// fpid_div
// Restoring divider, one quotient bit per cycle while ctrl_i.step is set, quotient truncated to zero.
// ----------------------------------------------------------------------------
module fpid_div (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  fpid_pkg::div_ctrl_t                  ctrl_i,
  input  logic signed [fpid_pkg::DIFF_W-1:0]   dividend_i,
  input  logic        [fpid_pkg::PER_W-1:0]    divisor_i,
  output logic signed [fpid_pkg::DIFF_W-1:0]   quotient_o,
  output logic                                 last_o
);
  import fpid_pkg::*;

  logic                 neg_q, neg_d;
  logic [MAG_W-1:0]     quo_q, quo_d;
  logic [PER_W-1:0]     rem_q, rem_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  logic [DIFF_W-1:0]    mag_full;
  logic [PER_W:0]       trial;
  logic [PER_W:0]       trial_sub;
  logic [DIFF_W-1:0]    quo_ext;

  // Magnitude of the dividend; it always fits in MAG_W bits.
  assign mag_full = dividend_i[DIFF_W-1] ? DIFF_W'(-dividend_i) : DIFF_W'(dividend_i);

  // One restoring iteration: shift in the next dividend bit, subtract if it fits.
  assign trial     = {rem_q, quo_q[MAG_W-1]};
  assign trial_sub = trial - {1'b0, divisor_i};

  always_comb begin
    neg_d = neg_q;
    quo_d = quo_q;
    rem_d = rem_q;
    cnt_d = cnt_q;
    if (ctrl_i.start) begin
      neg_d = dividend_i[DIFF_W-1];
      quo_d = mag_full[MAG_W-1:0];
      rem_d = '0;
      cnt_d = '0;
    end else if (ctrl_i.step) begin
      if (trial >= {1'b0, divisor_i}) begin
        rem_d = trial_sub[PER_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b1};
      end else begin
        rem_d = trial[PER_W-1:0];
        quo_d = {quo_q[MAG_W-2:0], 1'b0};
      end
      cnt_d = cnt_q + DIV_CNT_W'(1);
    end
  end

  // Iteration counter is control state; the operands are payload.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q <= neg_d;
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign last_o     = (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
  assign quo_ext    = {{(DIFF_W-MAG_W){1'b0}}, quo_q};
  assign quotient_o = neg_q ? $signed(-quo_ext) : $signed(quo_ext);

endmodule

[rtl/fixed_point_pid_controller_top.sv]
// ----------------------------------------------------------------------------
// fixed_point_pid_controller_top: microcoded fixed-point PID controller.
// Each sample runs the whole microcode program, with the 33 iterations of the
// bit-serial derivative divider, before the next sample is accepted.
// Reset clears gains, integral and last error, opens every limit to the full
// 32-bit range and sets the period to 1.
// ----------------------------------------------------------------------------
module fixed_point_pid_controller_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream. tdata: measured [31:0], target [63:32].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [63:0]                        s_axis_tdata,
  // Output stream. tdata: control [31:0], p_term [63:32], i_term [95:64],
  // d_term [127:96].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [127:0]                       m_axis_tdata,
  // Configuration writes.
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [fpid_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [fpid_pkg::DATA_W-1:0]        cfg_data_i
);
  import fpid_pkg::*;

`include "fixed_point_pid_controller_top_assert.svh"

  // Configuration registers.
  logic signed [DATA_W-1:0] kp_q, ki_q, kd_q;
  logic        [PER_W-1:0]  per_q;
  logic signed [DATA_W-1:0] imax_q, imin_q, omax_q, omin_q;

  // Sequencer.
  logic [STEP_W-1:0] step_q, step_d;
  ucode_t            uw;
  logic              hold;

  // Datapath.
  logic signed [ERR_W-1:0]  err_q;
  logic signed [ERR_W-1:0]  prev_q;
  logic signed [DATA_W-1:0] integral_q;
  logic signed [DATA_W-1:0] tmp_q, p_q, d_q;
  logic signed [DIFF_W-1:0] quo_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [DATA_W-1:0] sat_val;
  logic signed [DATA_W-1:0] integ_new;
  logic signed [DATA_W-1:0] total;
  logic signed [DIFF_W-1:0] diff;
  logic        [PER_W-1:0]  per_eff;
  logic signed [ERR_W-1:0]  err_in;

  // Output register.
  logic         out_valid_q;
  logic [127:0] out_data_q;

  // Divider.
  logic signed [DIFF_W-1:0] div_quo;
  logic                     div_last;

  logic in_xfer, out_xfer, out_load;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (step_q == STEP_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_xfer      = out_valid_q && m_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // A zero period counts as one.
  assign per_eff = (per_q == '0) ? PER_W'(1) : per_q;

  // Configuration write decode.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q   <= '0;
      ki_q   <= '0;
      kd_q   <= '0;
      per_q  <= PER_W'(1);
      imax_q <= WORD_MAX;
      imin_q <= WORD_MIN;
      omax_q <= WORD_MAX;
      omin_q <= WORD_MIN;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_KP:   kp_q   <= cfg_data_i;
        CFG_KI:   ki_q   <= cfg_data_i;
        CFG_KD:   kd_q   <= cfg_data_i;
        CFG_PER:  per_q  <= cfg_data_i[PER_W-1:0];
        CFG_IMAX: imax_q <= cfg_data_i;
        CFG_IMIN: imin_q <= cfg_data_i;
        CFG_OMAX: omax_q <= cfg_data_i;
        CFG_OMIN: omin_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Microcode fetch and branch condition.
  assign uw = ucode_rom(step_q);

  always_comb begin
    case (uw.cond)
      COND_NO_INPUT: hold = !in_xfer;
      COND_DIV_BUSY: hold = !div_last;
      COND_OUT_BUSY: hold = out_valid_q && !m_axis_tready;
      default:       hold = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      step_d = uw.target;
    end else if (uw.last) begin
      step_d = STEP_IDLE;
    end else begin
      step_d = step_q + STEP_W'(1);
    end
  end

  assign out_load = (uw.alu == ALU_TOTAL) && !hold;

  // Shared multiplier operand selection.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (uw.mul)
      MUL_KP_ERR: begin
        mul_a = {{(MUL_W-DATA_W){kp_q[DATA_W-1]}}, kp_q};
        mul_b = {{(MUL_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      MUL_KI_ERR: begin
        mul_a = {{(MUL_W-DATA_W){ki_q[DATA_W-1]}}, ki_q};
        mul_b = {{(MUL_W-ERR_W){err_q[ERR_W-1]}}, err_q};
      end
      MUL_TMP_PER: begin
        mul_a = {{(MUL_W-DATA_W){tmp_q[DATA_W-1]}}, tmp_q};
        mul_b = {{(MUL_W-PER_W){1'b0}}, per_eff};
      end
      MUL_KD_QUO: begin
        mul_a = {{(MUL_W-DATA_W){kd_q[DATA_W-1]}}, kd_q};
        mul_b = quo_q;
      end
      default: ;
    endcase
  end

  // Error, derivative difference, saturation and the two clamps.
  assign err_in = $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
                - $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
  assign diff    = {err_q[ERR_W-1], err_q} - {prev_q[ERR_W-1], prev_q};
  assign sat_val = sat32(prod_q);
  assign integ_new = clamp32({{(DIFF_W-DATA_W){integral_q[DATA_W-1]}}, integral_q}
                           + {{(DIFF_W-DATA_W){tmp_q[DATA_W-1]}}, tmp_q},
                             imax_q, imin_q);
  assign total = clamp32({{(DIFF_W-DATA_W){p_q[DATA_W-1]}}, p_q}
                       + {{(DIFF_W-DATA_W){integral_q[DATA_W-1]}}, integral_q}
                       + {{(DIFF_W-DATA_W){d_q[DATA_W-1]}}, d_q},
                         omax_q, omin_q);

  // Control state and controller state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= STEP_IDLE;
      out_valid_q <= 1'b0;
      integral_q  <= '0;
      prev_q      <= '0;
    end else begin
      step_q <= step_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_xfer) begin
        out_valid_q <= 1'b0;
      end
      if (uw.alu == ALU_INTEG) begin
        integral_q <= integ_new;
        prev_q     <= err_q;
      end
    end
  end

  // Datapath payload registers.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      err_q <= err_in;
    end
    if (uw.mul != MUL_NONE) begin
      prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
    end
    case (uw.sat)
      SAT_P:   p_q   <= sat_val;
      SAT_TMP: tmp_q <= sat_val;
      SAT_D:   d_q   <= sat_val;
      default: ;
    endcase
    if (uw.alu == ALU_QUO) begin
      quo_q <= div_quo;
    end
    if (out_load) begin
      out_data_q <= {d_q >>> FRAC_BITS, integral_q >>> FRAC_BITS,
                     p_q >>> FRAC_BITS, total >>> FRAC_BITS};
    end
  end

  // Derivative divider: (error - last error) / period.
  fpid_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (uw.div),
    .dividend_i (diff),
    .divisor_i  (per_eff),
    .quotient_o (div_quo),
    .last_o     (div_last)
  );

  // Sequencer checks.
  `FPID_ASSERT_NXT(a_xfer_starts_program, in_xfer, step_q == STEP_MUL_P, "program did not start")
  `FPID_ASSERT_NXT(a_total_loads_output, out_load, out_valid_q && (step_q == STEP_IDLE), "result not registered")
  `FPID_ASSERT_NXT(a_div_exits_on_last, (step_q == STEP_DIV) && div_last, step_q == STEP_QUO, "divider loop did not exit")

endmodule

[verif/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the fixed-point PID controller
// The bench streams measured/target samples into the controller. It checks
// each returned control word and term against a local PID predictor. Gains,
// period and clamp limits are reprogrammed between phases while the block is
// idle. Both stream sides see random gaps and back-pressure.
// ----------------------------------------------------------------------------
module tb_top;

  // Predictor of the PID arithmetic plus the queue of outputs still owed by the block.
  class pid_result_checker;
    longint gain_p, gain_i, gain_d;
    longint period;
    longint integ_hi, integ_lo, out_hi, out_lo;
    longint integ_acc;
    longint last_err;
    logic [127:0] owed_outputs[$];
    int errors;
    int reports;
    string field_name[4] = '{"control", "p_term", "i_term", "d_term"};

    function new();
      gain_p    = 0;
      gain_i    = 0;
      gain_d    = 0;
      period    = 1;
      integ_hi  = longint'(fpid_pkg::WORD_MAX);
      integ_lo  = longint'(fpid_pkg::WORD_MIN);
      out_hi    = longint'(fpid_pkg::WORD_MAX);
      out_lo    = longint'(fpid_pkg::WORD_MIN);
      integ_acc = 0;
      last_err  = 0;
      errors    = 0;
      reports   = 0;
    endfunction

    function void write_reg(logic [fpid_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
      longint sval;
      sval = $signed(data);
      case (idx)
        fpid_pkg::CFG_KP:   gain_p = sval;
        fpid_pkg::CFG_KI:   gain_i = sval;
        fpid_pkg::CFG_KD:   gain_d = sval;
        fpid_pkg::CFG_PER:  period = {48'd0, data[15:0]};
        fpid_pkg::CFG_IMAX: integ_hi = sval;
        fpid_pkg::CFG_IMIN: integ_lo = sval;
        fpid_pkg::CFG_OMAX: out_hi = sval;
        fpid_pkg::CFG_OMIN: out_lo = sval;
        default: ;
      endcase
    endfunction

    // Exact product, saturated to the signed 32-bit range.
    function longint sat_product(longint a, longint b);
      logic signed [127:0] wa, wb, prod, lim_hi, lim_lo;
      wa     = a;
      wb     = b;
      lim_hi = fpid_pkg::WORD_MAX;
      lim_lo = fpid_pkg::WORD_MIN;
      prod   = wa * wb;
      if (prod > lim_hi) return longint'(fpid_pkg::WORD_MAX);
      if (prod < lim_lo) return longint'(fpid_pkg::WORD_MIN);
      return prod[63:0];
    endfunction

    // The upper limit wins first, so inverted limits yield one of the two.
    function longint limit(longint v, longint hi, longint lo);
      if (v > hi) return hi;
      if (v < lo) return lo;
      return v;
    endfunction

    function logic [31:0] frac_shift(longint v);
      longint s;
      s = v >>> fpid_pkg::FRAC_BITS;
      return s[31:0];
    endfunction

    // Advance the controller state by one sample and queue the output it owes.
    function void take_sample(logic [31:0] measured, logic [31:0] target);
      longint err, per, p_val, i_step, i_val, d_val, total, m_val, t_val;
      m_val     = $signed(measured);
      t_val     = $signed(target);
      err       = m_val - t_val;
      per       = (period == 0) ? 1 : period;
      p_val     = sat_product(gain_p, err);
      i_step    = sat_product(sat_product(gain_i, err), per);
      i_val     = limit(integ_acc + i_step, integ_hi, integ_lo);
      integ_acc = i_val;
      d_val     = sat_product((err - last_err) / per, gain_d);
      total     = limit(p_val + i_val + d_val, out_hi, out_lo);
      last_err  = err;
      owed_outputs.push_back({frac_shift(d_val), frac_shift(i_val),
                              frac_shift(p_val), frac_shift(total)});
    endfunction

    function void check_output(logic [127:0] data);
      logic [127:0] owed;
      if (owed_outputs.size() == 0) begin
        errors++;
        $display("%0t: output %h arrived with no sample outstanding", $time, data);
        return;
      end
      owed = owed_outputs.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (data[32*k +: 32] !== owed[32*k +: 32]) begin
          errors++;
          if (reports < 30) begin
            reports++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field_name[k],
                     owed[32*k +: 32], data[32*k +: 32]);
          end
        end
      end
    endfunction

    function int pending();
      return owed_outputs.size();
    endfunction
  endclass

  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned BLOCK_LATENCY = 44;
  localparam int unsigned CYCLE_LIMIT   = 2_500_000;
  localparam int unsigned RAND_PHASES   = 10;
  localparam int unsigned PHASE_ITEMS   = 133;

  logic                              clk_i;
  logic                              rst_ni        = 1'b0;
  logic                              s_axis_tvalid = 1'b0;
  logic                              s_axis_tready;
  // tdata: measured [31:0], target [63:32].
  logic [63:0]                       s_axis_tdata  = '0;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready = 1'b0;
  // tdata: control [31:0], p_term [63:32], i_term [95:64], d_term [127:96].
  logic [127:0]                      m_axis_tdata;
  logic                              cfg_valid_i   = 1'b0;
  logic                              cfg_ready_o;
  logic [fpid_pkg::CFG_IDX_W-1:0]    cfg_index_i   = fpid_pkg::CFG_KP;
  logic [31:0]                       cfg_data_i    = '0;

  pid_result_checker pid_chk = new();

  int unsigned cycle_cnt   = 0;
  int unsigned samples_in  = 0;
  int unsigned outputs_in  = 0;
  int unsigned reg_writes  = 0;
  int unsigned settings    = 0;
  bit          tx_steady   = 1'b0;
  bit          rx_steady   = 1'b0;

  fixed_point_pid_controller_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Free-running clock.
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Watchdog on the total run length.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Observe every transfer on the three channels.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        pid_chk.check_output(m_axis_tdata);
        outputs_in++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        pid_chk.write_reg(cfg_index_i, cfg_data_i);
        reg_writes++;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pid_chk.take_sample(s_axis_tdata[31:0], s_axis_tdata[63:32]);
        samples_in++;
      end
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 40);
    return $urandom_range(60, 150);
  endfunction

  // Output side back-pressure.
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!rx_steady) stall = pick_gap();
      end
    end
  end

  // Offer one sample and hold it until the transfer happens.
  task automatic send_sample(input logic [31:0] meas, input logic [31:0] tgt);
    int gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {tgt, meas};
    do @(posedge clk_i); while (!s_axis_tready);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= {$urandom, $urandom};
      repeat (gap - 1) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every owed output has been transferred.
  task automatic drain_outputs();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pid_chk.pending() != 0) @(posedge clk_i);
    repeat (BLOCK_LATENCY) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [fpid_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [31:0] per,
                               input logic [31:0] imax, input logic [31:0] imin,
                               input logic [31:0] omax, input logic [31:0] omin);
    write_reg(fpid_pkg::CFG_KP, kp);
    write_reg(fpid_pkg::CFG_KI, ki);
    write_reg(fpid_pkg::CFG_KD, kd);
    write_reg(fpid_pkg::CFG_PER, per);
    write_reg(fpid_pkg::CFG_IMAX, imax);
    write_reg(fpid_pkg::CFG_IMIN, imin);
    write_reg(fpid_pkg::CFG_OMAX, omax);
    write_reg(fpid_pkg::CFG_OMIN, omin);
    settings++;
  endtask

  function automatic longint rand_signed(int unsigned span);
    longint v;
    v = $urandom_range(0, span);
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  function automatic logic [31:0] rand_gain();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0:       return fpid_pkg::WORD_MAX;
      1:       return fpid_pkg::WORD_MIN;
      2:       return '0;
      3, 4, 5: return 32'(rand_signed(1 << 14));
      6, 7:    return 32'(rand_signed(1 << 22));
      default: return $urandom;
    endcase
  endfunction

  // Period in the low half; the upper half carries random bits that must be ignored.
  function automatic logic [31:0] rand_period();
    int r;
    logic [15:0] per;
    r = $urandom_range(0, 9);
    case (r)
      0:             per = '0;
      1:             per = 16'hFFFF;
      2:             per = 16'd1;
      3, 4, 5, 6, 7: per = 16'($urandom_range(1, 50));
      default:       per = 16'($urandom);
    endcase
    return {16'($urandom), per};
  endfunction

  function automatic void rand_limits(output logic [31:0] hi, output logic [31:0] lo);
    int r;
    logic signed [31:0] a, b;
    r = $urandom_range(0, 9);
    a = $urandom;
    b = $urandom;
    case (r)
      0, 1, 2, 3: begin
        hi = fpid_pkg::WORD_MAX;
        lo = fpid_pkg::WORD_MIN;
      end
      4, 5, 6: begin
        hi = (a > b) ? a : b;
        lo = (a > b) ? b : a;
      end
      7: begin
        hi = (a > b) ? b : a;
        lo = (a > b) ? a : b;
      end
      8: begin
        a  = $urandom_range(0, 1 << 24);
        hi = a;
        lo = -a;
      end
      default: begin
        hi = a;
        lo = a;
      end
    endcase
  endfunction

  function automatic logic [31:0] to_int32(longint v);
    if (v > longint'(fpid_pkg::WORD_MAX)) return fpid_pkg::WORD_MAX;
    if (v < longint'(fpid_pkg::WORD_MIN)) return fpid_pkg::WORD_MIN;
    return v[31:0];
  endfunction

  function automatic logic [31:0] rand_extreme();
    case ($urandom_range(0, 4))
      0:       return fpid_pkg::WORD_MAX;
      1:       return fpid_pkg::WORD_MIN;
      2:       return '0;
      3:       return 32'd1;
      default: return '1;
    endcase
  endfunction

  // Stimulus sequence.
  initial begin
    logic [31:0] kp, ki, kd, per, imax, imin, omax, omin;
    longint      meas, tgt;
    int unsigned span;
    int          r;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // Reset settings: all gains are zero, so every term must come out zero.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    send_sample(fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN);
    send_sample('0, '0);
    drain_outputs();

    // Unity gains with full limits: the largest errors saturate every product,
    // and the integral keeps adding to a saturated sum without wrapping.
    load_settings(32'(1 << fpid_pkg::FRAC_BITS), 32'(1 << fpid_pkg::FRAC_BITS),
                  32'(1 << fpid_pkg::FRAC_BITS), 32'd1,
                  fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN,
                  fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN);
    send_sample(32'd100, 32'd40);
    send_sample(fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN);
    send_sample(fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN);
    send_sample(fpid_pkg::WORD_MIN, fpid_pkg::WORD_MAX);
    send_sample(-32'sd5, -32'sd5);
    send_sample(32'd7, -32'sd9);
    drain_outputs();

    // Extreme gains with a zero period, which must act as a period of one.
    load_settings(fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN, fpid_pkg::WORD_MIN, 32'd0,
                  fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN,
                  fpid_pkg::WORD_MAX, fpid_pkg::WORD_MIN);
    send_sample(32'd1, 32'd0);
    send_sample(-32'sd1, 32'd0);
    send_sample(32'd0, 32'd0);
    send_sample(32'd123456, -32'sd654321);
    send_sample(fpid_pkg::WORD_MIN, fpid_pkg::WORD_MAX);
    drain_outputs();

    // Inverted integral and output limits with the longest period.
    load_settings(32'd5000, 32'd300, -32'sd70000, 32'hFFFF_FFFF,
                  -32'sd2000, 32'sd3000, -32'sd50000, 32'sd60000);
    send_sample(32'd0, 32'd0);
    send_sample(32'd1000, 32'd0);
    send_sample(-32'sd1000, 32'd0);
    send_sample(fpid_pkg::WORD_MAX, 32'd0);
    send_sample(32'd0, fpid_pkg::WORD_MAX);
    send_sample(32'd40000, -32'sd40000);
    drain_outputs();

    // Equal output limits pin the control word; the integral runs into its bound.
    load_settings(-32'sd1024, 32'd2048, 32'd0, 32'd7,
                  32'(1 << 20), -32'sd1048576, 32'd12345, 32'd12345);
    send_sample(32'd3000, 32'd0);
    send_sample(32'd3000, 32'd0);
    send_sample(32'd3000, 32'd0);
    drain_outputs();

    // Random phases: mostly a measurement settling toward a setpoint, with noise.
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      kp  = rand_gain();
      ki  = rand_gain();
      kd  = rand_gain();
      per = rand_period();
      rand_limits(imax, imin);
      rand_limits(omax, omin);
      load_settings(kp, ki, kd, per, imax, imin, omax, omin);
      tx_steady = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
      rx_steady = (phase % 4 == 1) || ($urandom_range(0, 4) == 0);
      span = 32'd1 << $urandom_range(4, 30);
      tgt  = rand_signed(span);
      meas = rand_signed(span);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          if (r < 4) tgt = rand_signed(span);
          meas = meas + ((tgt - meas) >>> 3) + rand_signed(span >> 4);
          send_sample(to_int32(meas), to_int32(tgt));
        end else if (r < 85) begin
          send_sample($urandom, $urandom);
        end else if (r < 92) begin
          send_sample(rand_extreme(), rand_extreme());
        end else begin
          send_sample(32'(rand_signed(255)), 32'(rand_signed(255)));
        end
        // Hold the input until the block has returned everything it owes.
        if (phase % 3 == 0 && i == PHASE_ITEMS / 2) drain_outputs();
      end
      drain_outputs();
    end

    $display("Summary: %0d samples and %0d outputs over %0d settings, %0d register writes.",
             samples_in, outputs_in, settings, reg_writes);
    $display("Settings covered zero and maximum periods, saturating gains, inverted limits.");
    if (pid_chk.errors == 0 && pid_chk.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fpid_pkg.sv
rtl/fpid_div.sv
rtl/fixed_point_pid_controller_top.sv
verif/tb_top.sv
